/* rtl/wmm_pkg.sv */
// Shared constants and codes for the windowed min/max tracker.
package wmm_pkg;

	localparam int NUM_CHOICES   = 3;
	localparam int WIN_BITS      = 32;
	localparam int CFG_BITS      = 32;
	localparam int CFG_IDX_BITS  = 1;
	localparam int OUT_BITS      = 32;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(100);

	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRACK_MIN     = 1'b1;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_RESEED = 1'b1;

endpackage

/* rtl/wmm_update.sv */
// Next-state logic: refresh, reseed and aging of the three ranked choices.
module wmm_update
	import wmm_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic                  func,
	input  logic [TIME_BITS-1:0]  sample_time,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic [WIN_BITS-1:0]   window_length,
	input  logic                  track_min,
	input  logic [TIME_BITS-1:0]  cur_times  [NUM_CHOICES],
	input  logic [VALUE_BITS-1:0] cur_values [NUM_CHOICES],
	output logic [TIME_BITS-1:0]  nxt_times  [NUM_CHOICES],
	output logic [VALUE_BITS-1:0] nxt_values [NUM_CHOICES]
);

	localparam int CMP_W = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

	function automatic logic as_good(input logic [VALUE_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b, input logic use_min);
		as_good = use_min ? (a <= b) : (a >= b);
	endfunction

	logic [TIME_BITS-1:0]  r_times  [NUM_CHOICES];
	logic [VALUE_BITS-1:0] r_values [NUM_CHOICES];
	logic [CMP_W-1:0]      win_ext;
	logic [CMP_W-1:0]      dt0;
	logic [CMP_W-1:0]      dt1;
	logic [CMP_W-1:0]      dt2;
	logic                  reseed;

	assign win_ext = CMP_W'(window_length);
	assign dt2     = CMP_W'(TIME_BITS'(sample_time - cur_times[2]));
	assign dt0     = CMP_W'(TIME_BITS'(sample_time - cur_times[0]));
	assign reseed  = (func == FUNC_RESEED) || as_good(sample_value, cur_values[0], track_min)
		|| (dt2 > win_ext);

	// refresh second and third choice by value
	always_comb begin
		r_times  = cur_times;
		r_values = cur_values;
		if (as_good(sample_value, cur_values[1], track_min)) begin
			r_times[1]  = sample_time;
			r_values[1] = sample_value;
			r_times[2]  = sample_time;
			r_values[2] = sample_value;
		end else if (as_good(sample_value, cur_values[2], track_min)) begin
			r_times[2]  = sample_time;
			r_values[2] = sample_value;
		end
	end

	assign dt1 = CMP_W'(TIME_BITS'(sample_time - r_times[1]));

	always_comb begin
		nxt_times  = r_times;
		nxt_values = r_values;
		if (reseed) begin
			for (int k = 0; k < NUM_CHOICES; k++) begin
				nxt_times[k]  = sample_time;
				nxt_values[k] = sample_value;
			end
		end else if (dt0 > win_ext) begin
			if (dt1 > win_ext) begin
				nxt_times[0]  = r_times[2];
				nxt_values[0] = r_values[2];
				nxt_times[1]  = sample_time;
				nxt_values[1] = sample_value;
			end else begin
				nxt_times[0]  = r_times[1];
				nxt_values[0] = r_values[1];
				nxt_times[1]  = r_times[2];
				nxt_values[1] = r_values[2];
			end
			nxt_times[2]  = sample_time;
			nxt_values[2] = sample_value;
		end else if ((r_times[1] == r_times[0]) && (dt0 > (win_ext >> 2))) begin
			nxt_times[1]  = sample_time;
			nxt_values[1] = sample_value;
			nxt_times[2]  = sample_time;
			nxt_values[2] = sample_value;
		end else if ((r_times[2] == r_times[1]) && (dt0 > (win_ext >> 1))) begin
			nxt_times[2]  = sample_time;
			nxt_values[2] = sample_value;
		end
	end

endmodule

/* rtl/windowed_min_max_tracker_core.sv */
// Top level: input stage, choice registers, result register and config port.
// Path: an accepted item goes to the input register, then to the result register.
// Throughput: one item per cycle unless the output stalls; choice registers close the loop.
// While a result waits, the input stage accepts only into an empty slot.
// Reset: window_length 100, max mode, all choices zero, both stages empty.
module windowed_min_max_tracker_core
	import wmm_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// func, sample_time, sample_value
	input  logic [((1+TIME_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tracked_value
	output logic [OUT_BITS-1:0] m_tdata
);

	logic                  valid_s1;
	logic                  func_s1;
	logic [TIME_BITS-1:0]  time_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [WIN_BITS-1:0]   window_q;
	logic                  track_min_q;
	logic [TIME_BITS-1:0]  times_q  [NUM_CHOICES];
	logic [VALUE_BITS-1:0] values_q [NUM_CHOICES];
	logic [TIME_BITS-1:0]  times_n  [NUM_CHOICES];
	logic [VALUE_BITS-1:0] values_n [NUM_CHOICES];
	logic [VALUE_BITS+OUT_BITS-1:0] best_ext;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;
	logic                  advance;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign best_ext = {{OUT_BITS{1'b0}}, values_n[0]};

	wmm_update #(
		.VALUE_BITS(VALUE_BITS),
		.TIME_BITS (TIME_BITS)
	) u_update (
		.func         (func_s1),
		.sample_time  (time_s1),
		.sample_value (value_s1),
		.window_length(window_q),
		.track_min    (track_min_q),
		.cur_times    (times_q),
		.cur_values   (values_q),
		.nxt_times    (times_n),
		.nxt_values   (values_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			track_min_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_LENGTH: window_q    <= WIN_BITS'(cfg_data);
				CFG_TRACK_MIN:     track_min_q <= cfg_data[0];
				default:           window_q    <= window_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1  <= s_tdata[0];
			time_s1  <= s_tdata[TIME_BITS:1];
			value_s1 <= s_tdata[TIME_BITS+VALUE_BITS:TIME_BITS+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHOICES; k++) begin
				times_q[k]  <= '0;
				values_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			times_q     <= times_n;
			values_q    <= values_n;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= best_ext[OUT_BITS-1:0];
		end
	end

endmodule
